// ----- rtl/phc_pkg.sv -----
// Shared constants, codes and command/status types for the pinned handle cache.
package phc_pkg;

  localparam int HANDLES = 192;
  localparam int IDX_W   = (HANDLES > 1) ? $clog2(HANDLES) : 1;
  localparam int ID_W    = 15;
  localparam int LOCK_W  = 15;
  localparam int SLOT_W  = 8;
  localparam int STAT_W  = 3;
  localparam int RC_W    = 16;

  localparam logic [RC_W-1:0]   RC_RESET = 16'd32768;
  localparam logic [LOCK_W-1:0] LOCK_MAX = 15'd32767;
  localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(HANDLES - 1);

  typedef enum logic {
    OP_LOCK   = 1'b0,
    OP_UNLOCK = 1'b1
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_HIT_HELD       = 3'd0,
    ST_HIT_REPINNED   = 3'd1,
    ST_MISS_LOADED    = 3'd2,
    ST_NO_FREE        = 3'd3,
    ST_UNLOCK_HELD    = 3'd4,
    ST_UNLOCK_RELEASE = 3'd5,
    ST_UNLOCK_MISSING = 3'd6,
    ST_OUT_OF_RANGE   = 3'd7
  } status_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [LOCK_W-1:0] locks;
  } entry_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
  } cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic in_range;
    logic last_issue;
    logic out_free;
  } stat_t;

endpackage

// ----- rtl/pinned_handle_cache_top.sv -----
// Pinned handle cache with round-robin replacement: top level.
// One request is handled at a time. After the input transfer the request is
// range-checked against resource_count; an out-of-range id goes straight to
// the commit without a scan. An in-range request scans the whole table of
// HANDLES slots through a two-port memory, one slot per port per cycle: port A
// walks the slots in order to find the first matching slot, port B walks from
// the replacement cursor to find the first unlocked slot. The next request is
// taken as soon as the result has been placed in the output register, even if
// that result is still awaiting transfer. The lock count saturates at 32767
// and never goes below zero. No clearing pass is needed after reset: per-slot
// valid bits mark empty slots.
module pinned_handle_cache_top (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_op,
  input  logic [phc_pkg::ID_W-1:0]   in_resource_id,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [phc_pkg::STAT_W-1:0] out_status,
  output logic [phc_pkg::SLOT_W-1:0] out_slot,
  output logic                       out_evicted_valid,
  output logic [phc_pkg::ID_W-1:0]   out_evicted_id,
  output logic [phc_pkg::LOCK_W-1:0] out_lock_count,
  input  logic                       cfg_wr_en,
  input  logic [phc_pkg::RC_W-1:0]   cfg_wr_data
);
  import phc_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  phc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .stat     (stat)
  );

  phc_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_op             (in_op),
    .in_resource_id    (in_resource_id),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_slot          (out_slot),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_id    (out_evicted_id),
    .out_lock_count    (out_lock_count)
  );

endmodule

// ----- rtl/phc_dp.sv -----
// Datapath of the pinned handle cache: table memory, scan, update and result register.
module phc_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  phc_pkg::cmd_t              cmd,
  output phc_pkg::stat_t             stat,
  input  logic                       in_op,
  input  logic [phc_pkg::ID_W-1:0]   in_resource_id,
  input  logic                       cfg_wr_en,
  input  logic [phc_pkg::RC_W-1:0]   cfg_wr_data,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [phc_pkg::STAT_W-1:0] out_status,
  output logic [phc_pkg::SLOT_W-1:0] out_slot,
  output logic                       out_evicted_valid,
  output logic [phc_pkg::ID_W-1:0]   out_evicted_id,
  output logic [phc_pkg::LOCK_W-1:0] out_lock_count
);
  import phc_pkg::*;

  entry_t               mem [HANDLES];
  logic [HANDLES-1:0]   valid_r;
  logic [RC_W-1:0]      rc_r;
  logic [IDX_W-1:0]     cursor_r, cursor_nxt;

  logic                 op_r;
  logic [ID_W-1:0]      id_r;
  logic                 in_range_r;

  logic [IDX_W-1:0]     cnt_r;
  logic [IDX_W-1:0]     b_idx_r;
  logic [IDX_W-1:0]     a_idx_d_r, b_idx_d_r;
  entry_t               rd_a_r, rd_b_r;
  logic                 rd_vld_r;

  logic                 hit_found_r, hit_found_nxt;
  logic [IDX_W-1:0]     hit_idx_r, hit_idx_nxt;
  logic [LOCK_W-1:0]    hit_locks_r, hit_locks_nxt;
  logic                 free_found_r, free_found_nxt;
  logic [IDX_W-1:0]     free_idx_r, free_idx_nxt;
  logic                 free_valid_r, free_valid_nxt;
  logic [ID_W-1:0]      free_id_r, free_id_nxt;

  logic                 a_match, b_free;

  status_t              res_status;
  logic [IDX_W-1:0]     res_idx;
  logic                 res_ev_valid;
  logic [ID_W-1:0]      res_ev_id;
  logic [LOCK_W-1:0]    res_count;
  logic                 wr_en, set_valid;
  logic [IDX_W-1:0]     wr_idx;
  entry_t               wr_word;

  logic                 out_valid_r;
  status_t              out_status_r;
  logic [SLOT_W-1:0]    out_slot_r;
  logic                 out_ev_valid_r;
  logic [ID_W-1:0]      out_ev_id_r;
  logic [LOCK_W-1:0]    out_count_r;

  // Configuration register and cursor.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rc_r     <= RC_RESET;
      cursor_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        rc_r <= cfg_wr_data;
      end
      cursor_r <= cursor_nxt;
    end
  end

  // Capture, range check; user must write the register only while idle (not enforced).
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r       <= in_op;
      id_r       <= in_resource_id;
      in_range_r <= ({1'b0, in_resource_id} < rc_r);
    end
  end

  // Two read ports: port A walks slots in order for the id match, port B walks
  // from the cursor for the first unlocked slot.
  always_ff @(posedge clk) begin
    if (cmd.scan) begin
      rd_a_r    <= mem[cnt_r];
      rd_b_r    <= mem[b_idx_r];
      a_idx_d_r <= cnt_r;
      b_idx_d_r <= b_idx_r;
    end
    if (cmd.commit && wr_en) begin
      mem[wr_idx] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      b_idx_r  <= '0;
      rd_vld_r <= 1'b0;
    end else if (cmd.load) begin
      cnt_r    <= '0;
      b_idx_r  <= cursor_r;
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan;
      if (cmd.scan) begin
        cnt_r   <= cnt_r + 1'b1;
        b_idx_r <= (b_idx_r == IDX_LAST) ? '0 : b_idx_r + 1'b1;
      end
    end
  end

  // An entry that is not valid reads as locks zero; its memory word is never trusted.
  always_comb begin
    a_match = rd_vld_r && valid_r[a_idx_d_r] && (rd_a_r.id == id_r);
    b_free  = rd_vld_r && (!valid_r[b_idx_d_r] || (rd_b_r.locks == '0));

    hit_found_nxt  = hit_found_r;
    hit_idx_nxt    = hit_idx_r;
    hit_locks_nxt  = hit_locks_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    free_valid_nxt = free_valid_r;
    free_id_nxt    = free_id_r;

    if (a_match && !hit_found_r) begin
      hit_found_nxt = 1'b1;
      hit_idx_nxt   = a_idx_d_r;
      hit_locks_nxt = rd_a_r.locks;
    end
    if (b_free && !free_found_r) begin
      free_found_nxt = 1'b1;
      free_idx_nxt   = b_idx_d_r;
      free_valid_nxt = valid_r[b_idx_d_r];
      free_id_nxt    = rd_b_r.id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
    end else if (cmd.load) begin
      hit_found_r  <= 1'b0;
      free_found_r <= 1'b0;
    end else begin
      hit_found_r  <= hit_found_nxt;
      free_found_r <= free_found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hit_idx_r    <= hit_idx_nxt;
    hit_locks_r  <= hit_locks_nxt;
    free_idx_r   <= free_idx_nxt;
    free_valid_r <= free_valid_nxt;
    free_id_r    <= free_id_nxt;
  end

  // Result and table update for the finished scan.
  always_comb begin
    res_status   = ST_OUT_OF_RANGE;
    res_idx      = '0;
    res_ev_valid = 1'b0;
    res_ev_id    = '0;
    res_count    = '0;
    wr_en        = 1'b0;
    set_valid    = 1'b0;
    wr_idx       = hit_idx_r;
    wr_word      = '{id: id_r, locks: '0};
    cursor_nxt   = cursor_r;

    priority if (!in_range_r) begin
      res_status = ST_OUT_OF_RANGE;
    end else if (op_r == OP_LOCK) begin
      priority if (hit_found_r) begin
        res_idx = hit_idx_r;
        wr_en   = 1'b1;
        if (hit_locks_r == '0) begin
          res_status = ST_HIT_REPINNED;
          res_count  = LOCK_W'(1);
        end else begin
          res_status = ST_HIT_HELD;
          res_count  = (hit_locks_r == LOCK_MAX) ? LOCK_MAX : LOCK_W'(hit_locks_r + 1'b1);
        end
        wr_word.locks = res_count;
      end else if (free_found_r) begin
        res_status    = ST_MISS_LOADED;
        res_idx       = free_idx_r;
        res_ev_valid  = free_valid_r;
        res_ev_id     = free_valid_r ? free_id_r : '0;
        res_count     = LOCK_W'(1);
        wr_en         = 1'b1;
        set_valid     = 1'b1;
        wr_idx        = free_idx_r;
        wr_word.locks = LOCK_W'(1);
        if (cmd.commit) begin
          cursor_nxt = (free_idx_r == IDX_LAST) ? '0 : free_idx_r + 1'b1;
        end
      end else begin
        res_status = ST_NO_FREE;
      end
    end else begin
      priority if (!hit_found_r) begin
        res_status = ST_UNLOCK_MISSING;
      end else if (hit_locks_r == '0) begin
        res_status = ST_UNLOCK_HELD;
        res_idx    = hit_idx_r;
      end else begin
        res_idx       = hit_idx_r;
        res_count     = LOCK_W'(hit_locks_r - 1'b1);
        res_status    = (res_count == '0) ? ST_UNLOCK_RELEASE : ST_UNLOCK_HELD;
        wr_en         = 1'b1;
        wr_word.locks = res_count;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (cmd.commit && set_valid) begin
      valid_r[free_idx_r] <= 1'b1;
    end
  end

  // Result register: frees on a transfer, loads on commit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r   <= res_status;
      out_slot_r     <= SLOT_W'(res_idx);
      out_ev_valid_r <= res_ev_valid;
      out_ev_id_r    <= res_ev_id;
      out_count_r    <= res_count;
    end
  end

  assign stat.in_range   = in_range_r;
  assign stat.last_issue = (cnt_r == IDX_LAST);
  assign stat.out_free   = !out_valid_r || !out_stall;

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_slot          = out_slot_r;
  assign out_evicted_valid = out_ev_valid_r;
  assign out_evicted_id    = out_ev_id_r;
  assign out_lock_count    = out_count_r;

`ifndef SYNTH
  a_commit_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !(out_valid_r && out_stall))
    else $error("result overwritten while waiting for transfer");

  a_valid_only_on_commit: assert property (@(posedge clk) disable iff (!rst_n)
    (rst_n && $past(rst_n) && !$past(cmd.commit)) |-> $stable(valid_r))
    else $error("valid bits changed outside a commit");

  a_cursor_in_table: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= IDX_LAST)
    else $error("replacement cursor beyond table");

  a_out_rise_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.commit))
    else $error("result appeared without a commit");
`endif

endmodule

// ----- rtl/phc_ctrl.sv -----
// Controller of the pinned handle cache: sequences capture, table scan and commit.
module phc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output phc_pkg::cmd_t  cmd,
  input  phc_pkg::stat_t stat
);
  import phc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CHECK  = 5'b00010,
    S_SCAN   = 5'b00100,
    S_DRAIN  = 5'b01000,
    S_COMMIT = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt  = state_r;
    cmd.load   = 1'b0;
    cmd.scan   = 1'b0;
    cmd.commit = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        cmd.load = accept;
        if (accept) begin
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        state_nxt = stat.in_range ? S_SCAN : S_COMMIT;
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.last_issue) begin
          state_nxt = S_DRAIN;
        end
      end
      // The last read word is evaluated here.
      S_DRAIN: begin
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTH
  a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_CHECK))
    else $error("accepted transfer did not start a request");

  a_commit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (stat.out_free && (state_r == S_COMMIT)))
    else $error("commit issued without room for the result");
`endif

endmodule
